// File: design/cals_pkg.sv
// shared types and constants for the command line argument splitter
package cals_pkg;

  localparam int unsigned MAX_RUN_DEF     = 255;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned MAX_RES         = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // one result item
  typedef struct packed {
    logic [7:0] out_char;
    logic [7:0] repeat_res;
    logic       arg_end;
  } result_t;

  // all results caused by one input item, slot 0 first
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            num;
  } bundle_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_head_t;

  function automatic result_t mk_res(logic [7:0] ch, logic [7:0] rep, logic fin);
    result_t r;
    r.out_char   = ch;
    r.repeat_res = rep;
    r.arg_end    = fin;
    return r;
  endfunction

endpackage

// File: design/cals_front.sv
// front end: parse state and classification of each byte into a result bundle
module cals_front #(
  parameter int unsigned MaxRun = cals_pkg::MAX_RUN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_char_i,
  output cals_pkg::bundle_t bundle_o,
  output logic             has_res_o
);
  import cals_pkg::*;

  localparam logic [7:0] RunCap = (MaxRun < 255) ? 8'(MaxRun) : 8'd255;

  localparam logic [1:0] ModeBetween = 2'd0;
  localparam logic [1:0] ModePlain   = 2'd1;
  localparam logic [1:0] ModeQuoted  = 2'd2;
  localparam logic [1:0] ModeQpend   = 2'd3;

  logic [1:0] mode_q, mode_d;
  logic [7:0] cnt_q, cnt_d;
  bundle_t    b;

  always_comb begin
    logic       done;
    logic       sep;
    logic [1:0] m;
    b       = '0;
    done    = 1'b0;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    m       = mode_q;
    sep     = (in_char_i == CH_SPACE) || (in_char_i == CH_TAB);

    // pending backslash run
    if (cnt_q != 8'd0) begin
      if (in_char_i == CH_BSLASH) begin
        if (cnt_q < RunCap) begin
          cnt_d = cnt_q + 8'd1;
        end
        done = 1'b1;
      end else if (in_char_i == CH_QUOTE) begin
        cnt_d = 8'd0;
        if (cnt_q[7:1] != 7'd0) begin
          b.res[b.num] = mk_res(CH_BSLASH, {1'b0, cnt_q[7:1]}, 1'b0);
          b.num        = b.num + 2'd1;
        end
        if (cnt_q[0]) begin
          // odd run: escaped quote, quoting untouched
          b.res[b.num] = mk_res(CH_QUOTE, 8'd1, 1'b0);
          b.num        = b.num + 2'd1;
          done         = 1'b1;
        end
      end else begin
        b.res[b.num] = mk_res(CH_BSLASH, cnt_q, 1'b0);
        b.num        = b.num + 2'd1;
        cnt_d        = 8'd0;
      end
    end

    // quote seen inside quotes: doubled or closing
    if (!done && (m == ModeQpend)) begin
      if (in_char_i == CH_QUOTE) begin
        b.res[b.num] = mk_res(CH_QUOTE, 8'd1, 1'b0);
        b.num        = b.num + 2'd1;
        mode_d       = ModeQuoted;
        done         = 1'b1;
      end else begin
        m      = ModePlain;
        mode_d = ModePlain;
      end
    end

    if (!done) begin
      case (m)
        ModeBetween: begin
          if ((in_char_i == CH_NUL) || sep) begin
            mode_d = ModeBetween;
          end else if (in_char_i == CH_QUOTE) begin
            mode_d = ModeQuoted;
          end else if (in_char_i == CH_BSLASH) begin
            mode_d = ModePlain;
            cnt_d  = 8'd1;
          end else begin
            b.res[b.num] = mk_res(in_char_i, 8'd1, 1'b0);
            b.num        = b.num + 2'd1;
            mode_d       = ModePlain;
          end
        end
        ModePlain: begin
          if ((in_char_i == CH_NUL) || sep) begin
            b.res[b.num] = mk_res(CH_NUL, 8'd0, 1'b1);
            b.num        = b.num + 2'd1;
            mode_d       = ModeBetween;
          end else if (in_char_i == CH_QUOTE) begin
            mode_d = ModeQuoted;
          end else if (in_char_i == CH_BSLASH) begin
            cnt_d = 8'd1;
          end else begin
            b.res[b.num] = mk_res(in_char_i, 8'd1, 1'b0);
            b.num        = b.num + 2'd1;
          end
        end
        default: begin
          // inside quotes
          if (in_char_i == CH_NUL) begin
            b.res[b.num] = mk_res(CH_NUL, 8'd0, 1'b1);
            b.num        = b.num + 2'd1;
            mode_d       = ModeBetween;
          end else if (in_char_i == CH_QUOTE) begin
            mode_d = ModeQpend;
          end else if (in_char_i == CH_BSLASH) begin
            cnt_d = 8'd1;
          end else begin
            b.res[b.num] = mk_res(in_char_i, 8'd1, 1'b0);
            b.num        = b.num + 2'd1;
          end
        end
      endcase
    end
  end

  assign bundle_o  = b;
  assign has_res_o = (b.num != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBetween;
      cnt_q  <= 8'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: design/cals_queue.sv
// short bundle queue between front and back end
module cals_queue #(
  parameter int unsigned Depth = cals_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cals_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output cals_pkg::q_head_t head_o
);
  import cals_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: design/cals_back.sv
// back end: serializes one bundle into result items on the output stream
module cals_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cals_pkg::q_head_t head_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output cals_pkg::result_t m_res_o,
  output logic              m_last_o
);
  import cals_pkg::*;

  logic       busy_q, busy_d;
  bundle_t    bund_q;
  logic [1:0] idx_q, idx_d;
  logic       fire, last_now, load;

  assign last_now  = (idx_q == (bund_q.num - 2'd1));
  assign fire      = busy_q && m_ready_i;
  assign load      = !busy_q || (fire && last_now);
  assign pop_o     = load && head_i.valid;
  assign m_valid_o = busy_q;
  assign m_res_o   = bund_q.res[idx_q];
  assign m_last_o  = last_now;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = head_i.valid;
      idx_d  = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bund_q <= head_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// File: design/command_line_argument_splitter_top.sv
// top level of the command line argument splitter
//
// channel   dir  tdata                              tuser      tlast
// s_axis    in   [7:0] in_char                      -          -
// m_axis    out  [7:0] out_char, [15:8] repeat_res  [0] arg_end last result of the item
//
// one input byte is taken per cycle while the queue has room; the front end
// classifies it in the same cycle and pushes its one or two results, if any,
// into the bundle queue; the back end sends one result per cycle while
// m_axis_tready is high; that output port sets the sustained rate under heavy output
// reset clears parse mode, backslash count, queue pointers and output valid
// s_axis_tready drops only when the queue is full; output stalls fill the queue
module command_line_argument_splitter_top #(
  parameter int unsigned MAX_RUN     = cals_pkg::MAX_RUN_DEF,
  parameter int unsigned QUEUE_DEPTH = cals_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [15:8] repeat_res
  output logic        m_axis_tuser,   // [0] arg_end
  output logic        m_axis_tlast
);
  import cals_pkg::*;

  bundle_t   front_bundle;
  logic      front_has_res;
  logic      q_full;
  logic      accept;
  logic      pop;
  q_head_t   head;
  result_t   res;

  // an item enters whenever the queue has room, results or not
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cals_front #(
    .MaxRun (MAX_RUN)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (s_axis_tdata),
    .bundle_o  (front_bundle),
    .has_res_o (front_has_res)
  );

  // only bytes that produce results take a queue slot
  cals_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && front_has_res),
    .push_data_i (front_bundle),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  cals_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res),
    .m_last_o  (m_axis_tlast)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {res.repeat_res, res.out_char};
  assign m_axis_tuser = res.arg_end;

endmodule
